FILE: rtl/frms_pkg.sv
// shared types, constants and register codes of the frame rms and peak meter
package frms_pkg;

	// channel and frame limits
	localparam int MAX_CHANNELS      = 2;
	localparam int MAX_FRAME_SAMPLES = 4096;
	localparam int SAMPLE_BITS       = 16;

	// field and state widths
	localparam int CH_W      = 1;
	localparam int NCH_W     = 2;
	localparam int SPF_W     = 13;
	localparam int SMP_IDX_W = 12;
	localparam int LEVEL_W   = 16;
	localparam int SQ_W      = 32;
	localparam int SUM_W     = 42;

	// quarter scale floor of the running maxima
	localparam logic [LEVEL_W-1:0] LEVEL_FLOOR = LEVEL_W'(1 << (SAMPLE_BITS - 3));

	// configuration port
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_ADDR_W-1:0] REG_NUM_CHANNELS      = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_SAMPLES_PER_FRAME = 2'd1;
	localparam logic [NCH_W-1:0] NCH_RESET = 2'd2;
	localparam logic [SPF_W-1:0] SPF_RESET = 13'd1152;

	// input action codes
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_CLEAR  = 1'b1;

	// iteration counts of the shared divide and root unit
	localparam int STEP_W     = 6;
	localparam int DIV_STEPS  = SUM_W;
	localparam int SQRT_STEPS = LEVEL_W;

	typedef struct packed {
		logic                          action;
		logic signed [SAMPLE_BITS-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [CH_W-1:0]    channel;
		logic [LEVEL_W-1:0] rms_level;
		logic [LEVEL_W-1:0] peak_level;
		logic [LEVEL_W-1:0] max_rms;
		logic [LEVEL_W-1:0] max_peak;
		logic               last;
	} out_item_t;

endpackage

FILE: rtl/frame_rms_peak_meter.sv
// Frame RMS and peak level meter top level
// sample path: an audio sample passes the accept, square and accumulate steps; a clear acts when accepted
// frame end: per channel a start state, 42 divide steps and 16 root steps in the shared unit,
// then the result is loaded into the output register and held until taken
// requests: after a sample no new request is taken until it is accumulated, none during frame-end work
// reset: arst_n clears sums, peaks and position, maxima to quarter scale, registers 2 and 1152
module frame_rms_peak_meter import frms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SQUARE,
		S_ACCUM,
		S_START,
		S_ROOT,
		S_HOLD
	} state_t;

	state_t                 state_q;
	logic [NCH_W-1:0]       nch_q;
	logic [SPF_W-1:0]       spf_q;
	logic [SUM_W-1:0]       sum_q [MAX_CHANNELS];
	logic [LEVEL_W-1:0]     peak_q [MAX_CHANNELS];
	logic [SMP_IDX_W-1:0]   smp_idx_q;
	logic [CH_W-1:0]        ch_idx_q;
	logic [CH_W-1:0]        res_ch_q;
	logic [LEVEL_W-1:0]     max_rms_q;
	logic [LEVEL_W-1:0]     max_peak_q;
	logic [LEVEL_W-1:0]     mag_q;
	logic [SQ_W-1:0]        sq_q;
	logic                   out_valid_q;
	out_item_t              out_q;

	logic [NCH_W-1:0]       nch_eff;
	logic [SPF_W-1:0]       len_eff;
	logic [LEVEL_W-1:0]     mag_next;
	logic [CH_W-1:0]        sel_ch;
	logic [SUM_W:0]         sum_tot;
	logic [SUM_W-1:0]       sum_sat;
	logic                   ch_wrap;
	logic                   frame_end;
	logic                   res_last;
	logic                   in_acc;
	logic                   cfg_acc;
	logic                   unit_start;
	logic                   unit_done;
	logic [LEVEL_W-1:0]     unit_root;
	logic [LEVEL_W-1:0]     rms_max_next;
	logic [LEVEL_W-1:0]     peak_max_next;

	// handshakes, configuration wins over a sample in the same cycle
	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign in_acc    = in_valid && in_ready;

	// effective channel count and frame length
	always_comb begin
		if (nch_q == '0) begin
			nch_eff = NCH_W'(1);
		end else if (nch_q > NCH_W'(MAX_CHANNELS)) begin
			nch_eff = NCH_W'(MAX_CHANNELS);
		end else begin
			nch_eff = nch_q;
		end
		if (spf_q == '0) begin
			len_eff = SPF_W'(1);
		end else if (spf_q > SPF_W'(MAX_FRAME_SAMPLES)) begin
			len_eff = SPF_W'(MAX_FRAME_SAMPLES);
		end else begin
			len_eff = spf_q;
		end
	end

	// sample magnitude, most negative value gives full scale
	assign mag_next = in_item.sample[SAMPLE_BITS-1] ?
		LEVEL_W'(~in_item.sample + 1'b1) : LEVEL_W'(in_item.sample);

	// one channel slot is touched at a time
	assign sel_ch = (state_q == S_ACCUM) ? ch_idx_q : res_ch_q;

	// saturating sum of squares
	assign sum_tot = {1'b0, sum_q[sel_ch]} + (SUM_W + 1)'(sq_q);
	assign sum_sat = sum_tot[SUM_W] ? {SUM_W{1'b1}} : sum_tot[SUM_W-1:0];

	// frame position
	assign ch_wrap   = (NCH_W'(ch_idx_q) + NCH_W'(1)) >= nch_eff;
	assign frame_end = ch_wrap && ((SPF_W'(smp_idx_q) + SPF_W'(1)) >= len_eff);
	assign res_last  = (NCH_W'(res_ch_q) + NCH_W'(1)) == nch_eff;

	// running maxima with this channel's levels
	assign rms_max_next  = (unit_root > max_rms_q) ? unit_root : max_rms_q;
	assign peak_max_next = (peak_q[sel_ch] > max_peak_q) ? peak_q[sel_ch] : max_peak_q;

	assign unit_start = (state_q == S_START);

	frms_divsqrt u_divsqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (unit_start),
		.dividend (sum_q[sel_ch]),
		.divisor  (len_eff),
		.done     (unit_done),
		.root     (unit_root)
	);

	// sequencer, accumulators and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nch_q       <= NCH_RESET;
			spf_q       <= SPF_RESET;
			for (int c = 0; c < MAX_CHANNELS; c++) begin
				sum_q[c]  <= '0;
				peak_q[c] <= '0;
			end
			smp_idx_q   <= '0;
			ch_idx_q    <= '0;
			res_ch_q    <= '0;
			max_rms_q   <= LEVEL_FLOOR;
			max_peak_q  <= LEVEL_FLOOR;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cfg_acc) begin
						// any listed register write restarts the frame
						if (cfg_addr == REG_NUM_CHANNELS || cfg_addr == REG_SAMPLES_PER_FRAME) begin
							if (cfg_addr == REG_NUM_CHANNELS) begin
								nch_q <= cfg_data[NCH_W-1:0];
							end else begin
								spf_q <= cfg_data[SPF_W-1:0];
							end
							for (int c = 0; c < MAX_CHANNELS; c++) begin
								sum_q[c]  <= '0;
								peak_q[c] <= '0;
							end
							smp_idx_q <= '0;
							ch_idx_q  <= '0;
						end
					end else if (in_acc) begin
						if (in_item.action == ACT_CLEAR) begin
							max_rms_q  <= LEVEL_FLOOR;
							max_peak_q <= LEVEL_FLOOR;
						end else begin
							state_q <= S_SQUARE;
						end
					end
				end
				S_SQUARE: begin
					state_q <= S_ACCUM;
				end
				S_ACCUM: begin
					sum_q[sel_ch] <= sum_sat;
					if (mag_q > peak_q[sel_ch]) begin
						peak_q[sel_ch] <= mag_q;
					end
					if (!ch_wrap) begin
						ch_idx_q <= ch_idx_q + 1'b1;
						state_q  <= S_IDLE;
					end else begin
						ch_idx_q <= '0;
						if (frame_end) begin
							res_ch_q <= '0;
							state_q  <= S_START;
						end else begin
							smp_idx_q <= smp_idx_q + 1'b1;
							state_q   <= S_IDLE;
						end
					end
				end
				S_START: begin
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (unit_done) begin
						out_q.channel    <= res_ch_q;
						out_q.rms_level  <= unit_root;
						out_q.peak_level <= peak_q[sel_ch];
						out_q.max_rms    <= rms_max_next;
						out_q.max_peak   <= peak_max_next;
						out_q.last       <= res_last;
						max_rms_q        <= rms_max_next;
						max_peak_q       <= peak_max_next;
						out_valid_q      <= 1'b1;
						state_q          <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (res_last) begin
							for (int c = 0; c < MAX_CHANNELS; c++) begin
								sum_q[c]  <= '0;
								peak_q[c] <= '0;
							end
							smp_idx_q <= '0;
							ch_idx_q  <= '0;
							state_q   <= S_IDLE;
						end else begin
							res_ch_q <= res_ch_q + 1'b1;
							state_q  <= S_START;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// sample magnitude and its square
	always_ff @(posedge clk) begin
		if (in_acc && in_item.action == ACT_SAMPLE) begin
			mag_q <= mag_next;
		end
		if (state_q == S_SQUARE) begin
			sq_q <= SQ_W'(mag_q) * SQ_W'(mag_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

FILE: rtl/frms_divsqrt.sv
// shared compare and subtract unit: restoring divide by frame length, then integer square root
module frms_divsqrt import frms_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SUM_W-1:0]    dividend,
	input  logic [SPF_W-1:0]    divisor,
	output logic                done,
	output logic [LEVEL_W-1:0]  root
);

	typedef enum logic [1:0] {
		U_IDLE,
		U_DIV,
		U_SQRT
	} phase_t;

	phase_t              phase_q;
	logic [SUM_W-1:0]    work_q;
	logic [16:0]         rem_q;
	logic [LEVEL_W-1:0]  root_q;
	logic [STEP_W-1:0]   count_q;
	logic                done_q;

	logic [18:0] op_a;
	logic [18:0] op_b;
	logic [19:0] diff;
	logic        fits;

	// operand select for the one subtractor
	always_comb begin
		if (phase_q == U_DIV) begin
			op_a = {5'd0, rem_q[SPF_W-1:0], work_q[SUM_W-1]};
			op_b = {6'd0, divisor};
		end else begin
			op_a = {rem_q, work_q[31:30]};
			op_b = {1'b0, root_q, 2'b01};
		end
		diff = {1'b0, op_a} - {1'b0, op_b};
		fits = ~diff[19];
	end

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= U_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				U_IDLE: begin
					if (start) begin
						phase_q <= U_DIV;
						count_q <= STEP_W'(DIV_STEPS - 1);
					end
				end
				U_DIV: begin
					if (count_q == '0) begin
						phase_q <= U_SQRT;
						count_q <= STEP_W'(SQRT_STEPS - 1);
					end else begin
						count_q <= count_q - 1'b1;
					end
				end
				U_SQRT: begin
					if (count_q == '0) begin
						phase_q <= U_IDLE;
						done_q  <= 1'b1;
					end else begin
						count_q <= count_q - 1'b1;
					end
				end
				default: phase_q <= U_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (phase_q)
			U_IDLE: begin
				if (start) begin
					work_q <= dividend;
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			U_DIV: begin
				work_q <= {work_q[SUM_W-2:0], fits};
				if (count_q == '0) begin
					rem_q <= '0;
				end else if (fits) begin
					rem_q <= {4'd0, diff[SPF_W-1:0]};
				end else begin
					rem_q <= {4'd0, op_a[SPF_W-1:0]};
				end
			end
			U_SQRT: begin
				work_q <= {work_q[SUM_W-3:0], 2'b00};
				root_q <= {root_q[LEVEL_W-2:0], fits};
				rem_q  <= fits ? diff[16:0] : op_a[16:0];
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: tb/tb.sv
// self-checking testbench of the frame rms and peak meter, predictor based with random traffic
module tb import frms_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYC    = 600;
	localparam int QUIET_LIMIT = 5000;
	localparam int SETTLE_CYC  = 12;
	localparam int END_WAIT    = 200;
	localparam int RAND_ITEMS  = 500;
	localparam int MAX_SHOWN   = 10;
	localparam int RESET_CFG_ITEMS = 16;

	// indexes past the register list, writes there must change nothing
	localparam logic [CFG_ADDR_W-1:0] REG_NONE_LO = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_NONE_HI = 2'd3;

	localparam logic [63:0] SUM_LIMIT = (64'd1 << SUM_W) - 64'd1;
	localparam logic signed [SAMPLE_BITS-1:0] FS_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] FS_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

	typedef enum logic {ROW_REG, ROW_ITEM} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_ADDR_W-1:0] addr;
		logic [CFG_DATA_W-1:0] data;
		in_item_t              item;
		bit                    pinned;
		out_item_t             want;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_item;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_item;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_data;

	// typed-in expectation travelling with the request
	logic      pin_on;
	out_item_t pin_exp;

	out_item_t pending_levels[$];
	plan_row_t plan[$];
	int        bad_levels = 0;
	int        quiet_cyc = 0;
	int        hold_asks = 0;
	int        burst_left = 0;

	// predictor state
	logic [NCH_W-1:0]   lvl_nch;
	logic [SPF_W-1:0]   lvl_spf;
	logic [SUM_W-1:0]   acc_sq [MAX_CHANNELS];
	logic [LEVEL_W-1:0] acc_pk [MAX_CHANNELS];
	int unsigned        pos_smp;
	int unsigned        pos_ch;
	logic [LEVEL_W-1:0] top_rms;
	logic [LEVEL_W-1:0] top_pk;

	always #5 clk = ~clk;

	frame_rms_peak_meter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	// floor of the square root, one result bit per pass
	function automatic logic [LEVEL_W-1:0] root_floor(input logic [SUM_W-1:0] v);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int b = SUM_W / 2; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= 64'(v)) r = t;
		end
		return r[LEVEL_W-1:0];
	endfunction

	function automatic void restart_frame();
		for (int c = 0; c < MAX_CHANNELS; c++) begin
			acc_sq[c] = '0;
			acc_pk[c] = '0;
		end
		pos_smp = 0;
		pos_ch = 0;
	endfunction

	function automatic void reset_model();
		lvl_nch = NCH_RESET;
		lvl_spf = SPF_RESET;
		restart_frame();
		top_rms = LEVEL_FLOOR;
		top_pk = LEVEL_FLOOR;
	endfunction

	// any valid register write restarts the frame, maxima survive
	function automatic void apply_reg_write(input logic [CFG_ADDR_W-1:0] addr,
			input logic [CFG_DATA_W-1:0] data);
		case (addr)
			REG_NUM_CHANNELS: begin
				lvl_nch = data[NCH_W-1:0];
				restart_frame();
			end
			REG_SAMPLES_PER_FRAME: begin
				lvl_spf = data[SPF_W-1:0];
				restart_frame();
			end
			default: ;
		endcase
	endfunction

	// accumulate one request, queue the per channel levels at frame end
	function automatic int predict_levels(input in_item_t it);
		int unsigned nch;
		int unsigned len;
		logic [63:0] mag;
		logic [63:0] tot;
		out_item_t   lv;
		int          made;
		made = 0;
		nch = (lvl_nch == 0) ? 1 : (lvl_nch > MAX_CHANNELS) ? MAX_CHANNELS : int'(lvl_nch);
		len = (lvl_spf == 0) ? 1 :
			(lvl_spf > MAX_FRAME_SAMPLES) ? MAX_FRAME_SAMPLES : int'(lvl_spf);
		if (it.action == ACT_CLEAR) begin
			top_rms = LEVEL_FLOOR;
			top_pk = LEVEL_FLOOR;
		end else begin
			mag = 64'({1'b0, it.sample});
			if (it.sample[SAMPLE_BITS-1]) mag = (64'd1 << SAMPLE_BITS) - mag;
			tot = 64'(acc_sq[pos_ch]) + mag * mag;
			acc_sq[pos_ch] = (tot > SUM_LIMIT) ? SUM_LIMIT[SUM_W-1:0] : tot[SUM_W-1:0];
			if (mag > 64'(acc_pk[pos_ch])) acc_pk[pos_ch] = mag[LEVEL_W-1:0];
			if (pos_ch + 1 < nch) begin
				pos_ch++;
			end else begin
				pos_ch = 0;
				if (pos_smp + 1 < len) begin
					pos_smp++;
				end else begin
					for (int c = 0; c < nch; c++) begin
						lv.channel = CH_W'(c);
						lv.rms_level = root_floor(acc_sq[c] / SUM_W'(len));
						lv.peak_level = acc_pk[c];
						if (lv.rms_level > top_rms) top_rms = lv.rms_level;
						if (lv.peak_level > top_pk) top_pk = lv.peak_level;
						lv.max_rms = top_rms;
						lv.max_peak = top_pk;
						lv.last = (c + 1 == nch);
						pending_levels.push_back(lv);
						made++;
					end
					restart_frame();
				end
			end
		end
		return made;
	endfunction

	function automatic string show_level(input out_item_t v);
		return $sformatf("ch %0d rms %0d peak %0d max_rms %0d max_peak %0d last %0d",
			v.channel, v.rms_level, v.peak_level, v.max_rms, v.max_peak, v.last);
	endfunction

	function automatic void check_level(input out_item_t got);
		out_item_t want;
		if (pending_levels.size() == 0) begin
			bad_levels++;
			if (bad_levels <= MAX_SHOWN) $display("unexpected level result: %s", show_level(got));
		end else begin
			want = pending_levels.pop_front();
			if (got.channel !== want.channel || got.rms_level !== want.rms_level ||
					got.peak_level !== want.peak_level || got.max_rms !== want.max_rms ||
					got.max_peak !== want.max_peak || got.last !== want.last) begin
				bad_levels++;
				if (bad_levels <= MAX_SHOWN)
					$display("level mismatch: expected %s, got %s", show_level(want),
						show_level(got));
			end
		end
	endfunction

	// monitor: results are checked before the same edge's request is predicted
	always @(posedge clk) begin
		int made;
		if (arst_n) begin
			if (out_valid && out_ready) check_level(out_item);
			if (cfg_valid && cfg_ready) apply_reg_write(cfg_addr, cfg_data);
			if (in_valid && in_ready) begin
				made = predict_levels(in_item);
				if (pin_on && made == 1) pending_levels[pending_levels.size() - 1] = pin_exp;
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cyc <= 0;
		else
			quiet_cyc <= quiet_cyc + 1;
		if (quiet_cyc >= QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// receiver: rotating stall pattern, long hold-off when asked
	initial begin : receiver
		int unsigned mode;
		int unsigned mode_left;
		logic [15:0] pat;
		int          served;
		mode = 0;
		mode_left = 0;
		pat = '1;
		served = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asks != served) begin
				served++;
				out_ready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					pat = 16'($urandom);
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				case (mode)
					0: out_ready <= 1'b1;
					3: out_ready <= pat[0] & pat[1];
					default: out_ready <= pat[0];
				endcase
				pat = {pat[0], pat[15:1]};
			end
		end
	end

	// sender: bursts of requests with random gaps
	task automatic send_item(input in_item_t it, input bit pinned, input out_item_t want);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		in_valid <= 1'b1;
		in_item <= it;
		pin_on <= pinned;
		pin_exp <= want;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		burst_left--;
	endtask

	// stop sending and wait for every expected level plus the sample pipeline
	task automatic drain_levels();
		in_valid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (pending_levels.size() != 0) @(negedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
			input logic [CFG_DATA_W-1:0] data);
		drain_levels();
		cfg_valid <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= data;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic void plan_reg(input logic [CFG_ADDR_W-1:0] addr,
			input logic [CFG_DATA_W-1:0] data);
		plan_row_t r;
		r.kind = ROW_REG;
		r.addr = addr;
		r.data = data;
		r.item = '0;
		r.pinned = 1'b0;
		r.want = '0;
		plan.push_back(r);
	endfunction

	function automatic void plan_item(input logic action, input logic signed [SAMPLE_BITS-1:0] smp,
			input bit pinned, input out_item_t want);
		plan_row_t r;
		r.kind = ROW_ITEM;
		r.addr = '0;
		r.data = '0;
		r.item.action = action;
		r.item.sample = smp;
		r.pinned = pinned;
		r.want = want;
		plan.push_back(r);
	endfunction

	// single channel, single sample frame result
	function automatic out_item_t mono_level(input int rms, input int pk, input int mr,
			input int mp);
		out_item_t v;
		v.channel = '0;
		v.rms_level = LEVEL_W'(rms);
		v.peak_level = LEVEL_W'(pk);
		v.max_rms = LEVEL_W'(mr);
		v.max_peak = LEVEL_W'(mp);
		v.last = 1'b1;
		return v;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return FS_NEG;
			1: return FS_POS;
			2, 3: return SAMPLE_BITS'($urandom_range(0, 511)) - SAMPLE_BITS'(256);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic in_item_t pick_item();
		in_item_t it;
		it.action = ($urandom_range(0, 24) == 0) ? ACT_CLEAR : ACT_SAMPLE;
		it.sample = pick_sample();
		return it;
	endfunction

	initial begin : stimulus
		int                    rand_items;
		int                    ph;
		int                    n;
		int                    mid;
		logic [CFG_DATA_W-1:0] spf;
		in_item_t              it;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		pin_on = 1'b0;
		pin_exp = '0;
		reset_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// part of a frame in the reset configuration, no level may come out
		it.action = ACT_SAMPLE;
		repeat (RESET_CFG_ITEMS) begin
			it.sample = pick_sample();
			send_item(it, 1'b0, '0);
		end

		// directed table: extremes, clears, out of range registers, unused indexes
		plan_reg(REG_NUM_CHANNELS, 13'd1);
		plan_reg(REG_SAMPLES_PER_FRAME, 13'd1);
		plan_item(ACT_SAMPLE, 16'sd0, 1'b1, mono_level(0, 0, 8192, 8192));
		plan_item(ACT_SAMPLE, FS_NEG, 1'b1, mono_level(32768, 32768, 32768, 32768));
		plan_item(ACT_CLEAR, FS_POS, 1'b0, '0);
		plan_item(ACT_SAMPLE, FS_POS, 1'b1, mono_level(32767, 32767, 32767, 32767));
		plan_item(ACT_SAMPLE, 16'sd100, 1'b1, mono_level(100, 100, 32767, 32767));
		plan_item(ACT_CLEAR, -16'sd1, 1'b0, '0);
		plan_item(ACT_SAMPLE, 16'sd1, 1'b1, mono_level(1, 1, 8192, 8192));
		plan_item(ACT_SAMPLE, -16'sd1, 1'b1, mono_level(1, 1, 8192, 8192));
		plan_item(ACT_SAMPLE, 16'sd10000, 1'b1, mono_level(10000, 10000, 10000, 10000));
		plan_reg(REG_NUM_CHANNELS, 13'd0);
		plan_reg(REG_SAMPLES_PER_FRAME, 13'd0);
		plan_item(ACT_SAMPLE, 16'sd7, 1'b1, mono_level(7, 7, 10000, 10000));
		plan_reg(REG_NUM_CHANNELS, 13'd2);
		plan_reg(REG_SAMPLES_PER_FRAME, 13'd2);
		plan_item(ACT_SAMPLE, 16'sd3, 1'b0, '0);
		plan_item(ACT_SAMPLE, -16'sd4, 1'b0, '0);
		plan_item(ACT_SAMPLE, FS_POS, 1'b0, '0);
		plan_item(ACT_SAMPLE, FS_NEG, 1'b0, '0);
		plan_reg(REG_NUM_CHANNELS, 13'h1fff);
		plan_reg(REG_SAMPLES_PER_FRAME, 13'd3);
		plan_item(ACT_SAMPLE, 16'sd5, 1'b0, '0);
		plan_item(ACT_SAMPLE, -16'sd5, 1'b0, '0);
		plan_reg(REG_NONE_LO, 13'h1fff);
		plan_reg(REG_NONE_HI, 13'd0);
		plan_item(ACT_SAMPLE, 16'sd200, 1'b0, '0);
		plan_item(ACT_SAMPLE, -16'sd300, 1'b0, '0);
		plan_item(ACT_SAMPLE, FS_NEG, 1'b0, '0);
		plan_item(ACT_SAMPLE, FS_POS, 1'b0, '0);
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG)
				write_reg(plan[i].addr, plan[i].data);
			else
				send_item(plan[i].item, plan[i].pinned, plan[i].want);
		end

		// random phases with short frames
		rand_items = 0;
		ph = 0;
		while (rand_items < RAND_ITEMS) begin
			write_reg(REG_NUM_CHANNELS, CFG_DATA_W'($urandom));
			case ($urandom_range(0, 9))
				0: spf = '0;
				1: spf = 13'd1;
				8: spf = CFG_DATA_W'($urandom_range(13, 48));
				default: spf = CFG_DATA_W'($urandom_range(2, 12));
			endcase
			if (ph == 2) spf = 13'd1;
			write_reg(REG_SAMPLES_PER_FRAME, spf);
			n = $urandom_range(8, 64);
			mid = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n - 1) : -1;
			for (int k = 0; k < n; k++) begin
				// long receiver hold-off while requests keep coming
				if (ph == 2 && k == 2) hold_asks <= hold_asks + 1;
				// sender pause until every level is out
				if (ph == 4 && k == n / 2) drain_levels();
				if (k == mid) write_reg($urandom_range(0, 1) ? REG_NONE_LO : REG_NONE_HI,
					CFG_DATA_W'($urandom));
				send_item(pick_item(), 1'b0, '0);
				rand_items++;
			end
			ph++;
		end

		drain_levels();
		repeat (END_WAIT) @(posedge clk);
		bad_levels += pending_levels.size();
		if (bad_levels == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
